// ===== src/hhct_pkg.sv =====
// Package with the sizes and item types of the heavy hitter counter table.
`default_nettype none
package hhct_pkg;

    localparam int SLOTS       = 8;
    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_WIDTH = 16;
    localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef struct packed {
        logic signed [31:0] item_value;
        logic               end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         slot_index;
        logic signed [31:0] slot_value;
        logic [15:0]        slot_count;
        logic               dump_last;
    } t_out_item;

endpackage
`default_nettype wire

// ===== src/heavy_hitter_counter_table_unit.sv =====
// Streaming frequent-item table with one register stage in front of the slot table.
`default_nettype none
// The unit takes one item per clock while no dump runs: an accepted item is held
// in the input register and is then compared against all slots at once, updating
// the table in that cycle. An item marked end of stream triggers a dump of every
// slot in index order, one result per cycle while the output side is ready, and
// the table is cleared as the last slot is loaded. During the dump the input
// register holds the next item and takes no other, so an end of stream stalls
// the input side. Results leave through an output register.
module heavy_hitter_counter_table_unit
    import hhct_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [IDX_W-1:0]       LAST_IDX = IDX_W'(SLOTS - 1);

    logic                   r_in_valid;
    logic [VALUE_WIDTH-1:0] r_in_value;
    logic                   r_in_eos;

    logic [VALUE_WIDTH-1:0] r_val [SLOTS];
    logic [COUNT_WIDTH-1:0] r_cnt [SLOTS];
    logic [VALUE_WIDTH-1:0] n_val [SLOTS];
    logic [COUNT_WIDTH-1:0] n_cnt [SLOTS];

    logic                   r_dump;
    logic [IDX_W-1:0]       r_idx;

    logic [SLOTS-1:0]       match;
    logic [SLOTS-1:0]       empty;
    logic [SLOTS-1:0]       first_empty;
    logic                   proc;
    logic                   load;
    logic                   dump_end;
    t_out_item              dump_item;

    assign proc       = r_in_valid && !r_dump;
    assign o_in_ready = !r_in_valid || !r_dump;
    assign load       = r_dump && (!o_out_valid || i_out_ready);
    assign dump_end   = load && (r_idx == LAST_IDX);

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            empty[i] = (r_cnt[i] == '0);
            match[i] = !empty[i] && (r_val[i] == r_in_value);
        end
        first_empty = empty & (~empty + SLOTS'(1));
    end

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            n_val[i] = r_val[i];
            n_cnt[i] = r_cnt[i];
            if (|match) begin
                if (match[i] && r_cnt[i] != CNT_MAX) begin
                    n_cnt[i] = r_cnt[i] + COUNT_WIDTH'(1);
                end
            end else if (|empty) begin
                if (first_empty[i]) begin
                    n_val[i] = r_in_value;
                    n_cnt[i] = COUNT_WIDTH'(1);
                end
            end else begin
                n_cnt[i] = r_cnt[i] - COUNT_WIDTH'(1);
            end
        end
    end

    always_comb begin
        dump_item.slot_index = 3'(r_idx);
        dump_item.slot_value = 32'(signed'(r_val[r_idx]));
        dump_item.slot_count = 16'(r_cnt[r_idx]);
        dump_item.dump_last  = (r_idx == LAST_IDX);
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_value <= VALUE_WIDTH'(i_in_item.item_value);
            r_in_eos   <= i_in_item.end_of_stream;
        end
        if (load) begin
            o_out_item <= dump_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_dump      <= 1'b0;
            r_idx       <= '0;
            o_out_valid <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_val[i] <= '0;
                r_cnt[i] <= '0;
            end
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            if (proc) begin
                for (int i = 0; i < SLOTS; i++) begin
                    r_val[i] <= n_val[i];
                    r_cnt[i] <= n_cnt[i];
                end
                if (r_in_eos) begin
                    r_dump <= 1'b1;
                    r_idx  <= '0;
                end
            end
            if (dump_end) begin
                r_dump <= 1'b0;
                r_idx  <= '0;
                for (int i = 0; i < SLOTS; i++) begin
                    r_val[i] <= '0;
                    r_cnt[i] <= '0;
                end
            end else if (load) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    a_match_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc |-> $onehot0(match))
        else $error("More than one occupied slot matches the item.");

    a_clear_after_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dump_end |=> (empty == '1) && !r_dump)
        else $error("Table not cleared after the dump.");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.dump_last) |-> (o_out_item.slot_index == 3'(SLOTS - 1)))
        else $error("Last dump flag on the wrong slot.");

    a_no_take_in_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dump && r_in_valid) |=> $stable(r_in_value) && r_in_valid)
        else $error("Input register changed during the dump.");

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the heavy hitter counter table with a tracking table model.
`timescale 1ns / 1ps
module tb_top;
    import hhct_pkg::*;

    typedef enum int {
        PACE_FULL,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH,
        PACE_HOLD
    } t_pace;

    typedef struct {
        t_in_item item;
        t_pace    pace;
    } t_stream_entry;

    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 250;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    t_stream_entry stream_q[$];
    t_out_item     slot_reports_q[$];
    t_pace         cur_pace = PACE_FULL;
    int            mismatches = 0;
    int            hold_left = 0;
    bit            hold_done = 1'b0;

    logic signed [VALUE_WIDTH-1:0] tbl_value[SLOTS];
    logic [COUNT_WIDTH-1:0]        tbl_count[SLOTS];

    heavy_hitter_counter_table_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int send_idle_pct(t_pace p);
        case (p)
            PACE_SEND_IDLE: return 47;
            PACE_BOTH:      return 21;
            default:        return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(t_pace p);
        case (p)
            PACE_RECV_STALL: return 47;
            PACE_BOTH:       return 21;
            default:         return 0;
        endcase
    endfunction

    // Updates the tracked table for one item and queues the dump it causes.
    task automatic track_item(input t_in_item it);
        int        hit;
        int        free_slot;
        t_out_item rep;
        hit = -1;
        free_slot = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0 && tbl_count[i] != 0 && tbl_value[i] == it.item_value) begin
                hit = i;
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (free_slot < 0 && tbl_count[i] == 0) begin
                free_slot = i;
            end
        end
        if (hit >= 0) begin
            if (tbl_count[hit] != '1) begin
                tbl_count[hit] = tbl_count[hit] + COUNT_WIDTH'(1);
            end
        end else if (free_slot >= 0) begin
            tbl_value[free_slot] = it.item_value;
            tbl_count[free_slot] = COUNT_WIDTH'(1);
        end else begin
            for (int i = 0; i < SLOTS; i++) begin
                tbl_count[i] = tbl_count[i] - COUNT_WIDTH'(1);
            end
        end
        if (it.end_of_stream) begin
            for (int i = 0; i < SLOTS; i++) begin
                rep.slot_index = i[2:0];
                rep.slot_value = tbl_value[i];
                rep.slot_count = tbl_count[i];
                rep.dump_last  = (i == SLOTS - 1);
                slot_reports_q.push_back(rep);
                tbl_value[i] = '0;
                tbl_count[i] = '0;
            end
        end
    endtask

    task automatic push_item(input logic [31:0] value, input bit eos, input t_pace pace);
        t_stream_entry e;
        e.item.item_value    = value;
        e.item.end_of_stream = eos;
        e.pace               = pace;
        stream_q.push_back(e);
    endtask

    // One stream drawn mostly from a small pool of values so that some of them dominate.
    task automatic add_stream(input t_pace pace, input int len, inout int added);
        logic [31:0] pool[16];
        int          pool_n;
        int          a;
        int          b;
        logic [31:0] v;
        pool_n = $urandom_range(16, 1);
        for (int k = 0; k < pool_n; k++) begin
            case ($urandom_range(9))
                0:       pool[k] = 32'h8000_0000;
                1:       pool[k] = 32'h7FFF_FFFF;
                2:       pool[k] = 32'h0000_0000;
                3:       pool[k] = 32'hFFFF_FFFF;
                default: pool[k] = $urandom;
            endcase
        end
        for (int n = 0; n < len; n++) begin
            a = $urandom_range(pool_n - 1);
            b = $urandom_range(pool_n - 1);
            v = ($urandom_range(99) < 85) ? pool[(a < b) ? a : b] : $urandom;
            push_item(v, (n == len - 1), pace);
        end
        added += len;
    endtask

    always @(posedge i_clk) begin : p_drive
        t_stream_entry e;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (in_valid) begin
                track_item(in_item);
            end
            if (stream_q.size() != 0
                    && $urandom_range(99) >= send_idle_pct(stream_q[0].pace)) begin
                e = stream_q.pop_front();
                in_valid  <= 1'b1;
                in_item   <= e.item;
                cur_pace  <= e.pace;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : p_monitor
        t_out_item want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (slot_reports_q.size() == 0) begin
                    $error("unexpected slot report: index %0d", out_item.slot_index);
                    mismatches++;
                end else begin
                    want = slot_reports_q.pop_front();
                    if (out_item.slot_index !== want.slot_index) begin
                        $error("slot_index: expected %0d, got %0d",
                               want.slot_index, out_item.slot_index);
                        mismatches++;
                    end
                    if (out_item.slot_value !== want.slot_value) begin
                        $error("slot_value: expected %h, got %h",
                               want.slot_value, out_item.slot_value);
                        mismatches++;
                    end
                    if (out_item.slot_count !== want.slot_count) begin
                        $error("slot_count: expected %0d, got %0d",
                               want.slot_count, out_item.slot_count);
                        mismatches++;
                    end
                    if (out_item.dump_last !== want.dump_last) begin
                        $error("dump_last: expected %0b, got %0b",
                               want.dump_last, out_item.dump_last);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (cur_pace == PACE_HOLD && !hold_done) begin
                out_ready <= 1'b0;
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct(cur_pace));
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int    added;
        t_pace pace;
        added = 0;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_value[i] = '0;
            tbl_count[i] = '0;
        end

        push_item(32'h7FFF_FFFF, 1'b1, PACE_FULL);
        push_item(32'h8000_0000, 1'b0, PACE_FULL);
        push_item(32'h8000_0000, 1'b0, PACE_FULL);
        push_item(32'h0000_0000, 1'b0, PACE_FULL);
        push_item(32'hFFFF_FFFF, 1'b1, PACE_FULL);

        // Counts drop to zero but stale values stay; a later slot must still match
        // past an empty one, and stale values must not match.
        push_item(32'h0000_0001, 1'b0, PACE_FULL);
        push_item(32'hFFFF_FFFE, 1'b0, PACE_FULL);
        push_item(32'hFFFF_FFFE, 1'b0, PACE_FULL);
        push_item(32'h5555_5555, 1'b0, PACE_FULL);
        push_item(32'hAAAA_AAAA, 1'b0, PACE_FULL);
        push_item(32'h1234_5678, 1'b0, PACE_FULL);
        push_item(32'h8765_4321, 1'b0, PACE_FULL);
        push_item(32'h0F0F_0F0F, 1'b0, PACE_FULL);
        push_item(32'hF0F0_F0F0, 1'b0, PACE_FULL);
        push_item(32'h3C3C_3C3C, 1'b0, PACE_FULL);
        push_item(32'hFFFF_FFFE, 1'b0, PACE_FULL);
        push_item(32'hF0F0_F0F0, 1'b0, PACE_FULL);
        push_item(32'h0000_0001, 1'b0, PACE_FULL);
        push_item(32'h0000_0000, 1'b1, PACE_FULL);

        // Full table, end of stream on an unknown value empties every slot.
        for (int i = 0; i < SLOTS; i++) begin
            push_item(32'hC000_0000 + i, 1'b0, PACE_FULL);
        end
        push_item(32'h4000_0000, 1'b1, PACE_FULL);

        while (added < RANDOM_ITEMS) begin
            pace = t_pace'((added / 60) % 4);
            if ($urandom_range(9) == 0) begin
                add_stream(pace, 1, added);
            end else begin
                add_stream(pace, $urandom_range(40, 2), added);
            end
        end
        for (int s = 0; s < 6; s++) begin
            add_stream(PACE_HOLD, $urandom_range(6, 2), added);
        end
        for (int s = 0; s < 4; s++) begin
            add_stream(PACE_BOTH, $urandom_range(20, 2), added);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stream_q.size() != 0 || in_valid || slot_reports_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/hhct_pkg.sv
src/heavy_hitter_counter_table_unit.sv
verif/tb_top.sv
